// File: sv/jmss_pkg.sv
// Package for the JPEG marker segment splitter: byte role and error codes,
// marker constants and the packed result record. Depends on nothing.
`default_nettype none

package jmss_pkg;

  // Marker code bytes that the splitter treats specially.
  localparam logic [7:0] PREFIX_BYTE = 8'hFF;
  localparam logic [7:0] MARKER_SOI  = 8'hD8;
  localparam logic [7:0] MARKER_EOI  = 8'hD9;
  localparam logic [7:0] MARKER_SOS  = 8'hDA;

  // Register reset values.
  localparam logic [7:0] MARKER_LOW_RESET  = 8'hC0;
  localparam logic [7:0] MARKER_HIGH_RESET = 8'hFE;
  localparam logic [7:0] FILL_LIMIT_RESET  = 8'd10;

  // Configuration register indexes.
  localparam logic [1:0] REG_MARKER_LOW  = 2'd0;
  localparam logic [1:0] REG_MARKER_HIGH = 2'd1;
  localparam logic [1:0] REG_FILL_LIMIT  = 2'd2;

  // Byte roles.
  localparam logic [2:0] ROLE_FILL      = 3'd0;
  localparam logic [2:0] ROLE_MARKER    = 3'd1;
  localparam logic [2:0] ROLE_LEN_HI    = 3'd2;
  localparam logic [2:0] ROLE_LEN_LO    = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD   = 3'd4;
  localparam logic [2:0] ROLE_ENTROPY   = 3'd5;
  localparam logic [2:0] ROLE_PADDING   = 3'd6;
  localparam logic [2:0] ROLE_DISCARDED = 3'd7;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_MARKER  = 3'd1;
  localparam logic [2:0] ERR_BAD_MARKER = 3'd2;
  localparam logic [2:0] ERR_SHORT_LEN  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  role;
    logic [7:0]  section_marker;
    logic [15:0] payload_length;
    logic [2:0]  error_code;
    logic        file_end;
    logic        run_end;
  } result_t;

endpackage

`default_nettype wire

// File: sv/jpeg_marker_segment_splitter.sv
// JPEG marker segment splitter, top level: per-byte labelling logic and a
// four-entry result queue. Depends on jmss_pkg.
`default_nettype none

// The splitter takes a JPEG file one byte per transaction, with last_byte
// set on the final byte, and returns a labelled result for each byte: its
// role (fill or prefix, marker code, length high or low, payload, entropy
// data, padding or discarded), the marker of the section it belongs to, the
// payload length once known, and a sticky error code. One input byte is
// taken every clock cycle unless stalled. Most bytes give one result; an
// 0xFF in the entropy-coded data is held back for a byte and gives no
// result of its own, and is later released together with the following
// byte, giving up to two results in that transaction. The labelling is
// combinational logic on the accepted byte and the parser state; its
// results are written into a four-entry result queue, which delivers one
// result per cycle unless the output stalls. The input stalls while fewer
// than two queue entries are free, so with an output that never stalls
// the sustained rate is one byte per cycle. After the final
// byte of a file the parser returns to its reset state; the configuration
// registers keep their values. Configuration writes are always accepted
// (cfg_ready is held high) and must only be made while the block is idle.
module jpeg_marker_segment_splitter (
  input  wire logic         clk,
  input  wire logic         rst,
  // Byte input channel.
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire logic [7:0]   data_byte,
  input  wire logic         last_byte,
  // Result output channel.
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic [7:0]        out_byte,
  output logic [2:0]        role,
  output logic [7:0]        section_marker,
  output logic [15:0]       payload_length,
  output logic [2:0]        error_code,
  output logic              file_end,
  output logic              run_end,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);
  import jmss_pkg::*;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_SCAN
  } phase_t;

  // Configuration registers.
  logic [7:0] marker_low;
  logic [7:0] marker_high;
  logic [7:0] fill_limit;

  // Parser state.
  phase_t      phase;
  logic [7:0]  fill_count;
  logic [7:0]  current_marker;
  logic [7:0]  length_high;
  logic [15:0] bytes_remaining;
  logic        held_ff;
  logic [2:0]  sticky_error;
  logic        padding_mode;
  logic [15:0] shown_len;

  phase_t      phase_next;
  logic [7:0]  fill_count_next;
  logic [7:0]  current_marker_next;
  logic [7:0]  length_high_next;
  logic [15:0] bytes_remaining_next;
  logic        held_ff_next;
  logic [2:0]  sticky_error_next;
  logic        padding_mode_next;
  logic [15:0] shown_len_next;

  // Result queue.
  result_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  result_t     res0;
  result_t     res1;
  logic [1:0]  n_results;
  logic        item_accept;
  logic        result_accept;
  logic        truncated;
  logic [15:0] total_len;
  logic [8:0]  fill_plus_one;

  assign cfg_ready     = 1'b1;
  assign item_stall    = (count > QCNT_W'(QUEUE_DEPTH - 2));
  assign item_accept   = item_valid && !item_stall;
  assign result_valid  = (count != '0);
  assign result_accept = result_valid && !result_stall;

  assign out_byte       = queue[rd_ptr].out_byte;
  assign role           = queue[rd_ptr].role;
  assign section_marker = queue[rd_ptr].section_marker;
  assign payload_length = queue[rd_ptr].payload_length;
  assign error_code     = queue[rd_ptr].error_code;
  assign file_end       = queue[rd_ptr].file_end;
  assign run_end        = queue[rd_ptr].run_end;

  assign total_len     = {length_high, data_byte};
  assign fill_plus_one = {1'b0, fill_count} + 9'd1;

  // Labelling of one byte and the parser's next state.
  always_comb begin
    phase_next           = phase;
    fill_count_next      = fill_count;
    current_marker_next  = current_marker;
    length_high_next     = length_high;
    bytes_remaining_next = bytes_remaining;
    held_ff_next         = held_ff;
    sticky_error_next    = sticky_error;
    padding_mode_next    = padding_mode;
    shown_len_next       = shown_len;
    n_results            = 2'd0;
    truncated            = 1'b0;

    res0 = '{out_byte: data_byte, role: ROLE_DISCARDED, section_marker: current_marker,
             payload_length: shown_len, error_code: sticky_error,
             file_end: 1'b0, run_end: 1'b0};
    res1 = res0;

    if (sticky_error != ERR_NONE) begin
      n_results = 2'd1;
    end else if (padding_mode) begin
      n_results = 2'd1;
      res0.role = ROLE_PADDING;
    end else begin
      unique case (phase)
        PH_LEN_HI: begin
          length_high_next = data_byte;
          n_results        = 2'd1;
          res0.role        = ROLE_LEN_HI;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          n_results = 2'd1;
          if (total_len < 16'd2) begin
            sticky_error_next = ERR_SHORT_LEN;
            res0.error_code   = ERR_SHORT_LEN;
          end else begin
            shown_len_next       = total_len - 16'd2;
            bytes_remaining_next = total_len - 16'd2;
            res0.role            = ROLE_LEN_LO;
            res0.payload_length  = total_len - 16'd2;
            if (total_len == 16'd2) begin
              phase_next = (current_marker == MARKER_SOS) ? PH_SCAN : PH_SEEK;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          n_results            = 2'd1;
          res0.role            = ROLE_PAYLOAD;
          bytes_remaining_next = bytes_remaining - 16'd1;
          if (bytes_remaining == 16'd1) begin
            phase_next = (current_marker == MARKER_SOS) ? PH_SCAN : PH_SEEK;
          end
        end
        PH_SCAN: begin
          if (held_ff) begin
            res0.out_byte = PREFIX_BYTE;
            res0.role     = ROLE_ENTROPY;
            if (data_byte == MARKER_EOI) begin
              // The held 0xFF was the prefix of the end-of-image marker.
              held_ff_next        = 1'b0;
              current_marker_next = MARKER_EOI;
              shown_len_next      = 16'd0;
              padding_mode_next   = 1'b1;
              n_results           = 2'd2;
              res0.role           = ROLE_FILL;
              res0.section_marker = MARKER_EOI;
              res0.payload_length = 16'd0;
              res1                = res0;
              res1.out_byte       = data_byte;
              res1.role           = ROLE_MARKER;
            end else if (data_byte == PREFIX_BYTE && !last_byte) begin
              // Release the old 0xFF and hold the new one in its place.
              n_results = 2'd1;
            end else begin
              held_ff_next  = 1'b0;
              n_results     = 2'd2;
              res1          = res0;
              res1.out_byte = data_byte;
            end
          end else if (data_byte == PREFIX_BYTE && !last_byte) begin
            held_ff_next = 1'b1;
          end else begin
            n_results = 2'd1;
            res0.role = ROLE_ENTROPY;
          end
        end
        PH_SEEK: begin
          n_results = 2'd1;
          if (data_byte == PREFIX_BYTE) begin
            if (fill_plus_one >= {1'b0, fill_limit}) begin
              sticky_error_next = ERR_NO_MARKER;
              res0.error_code   = ERR_NO_MARKER;
            end else begin
              fill_count_next     = fill_plus_one[7:0];
              res0.role           = ROLE_FILL;
              res0.section_marker = 8'd0;
            end
          end else if (fill_count == 8'd0) begin
            sticky_error_next = ERR_NO_MARKER;
            res0.error_code   = ERR_NO_MARKER;
          end else begin
            fill_count_next = 8'd0;
            if (data_byte < marker_low || data_byte > marker_high) begin
              sticky_error_next = ERR_BAD_MARKER;
              res0.error_code   = ERR_BAD_MARKER;
            end else begin
              current_marker_next = data_byte;
              shown_len_next      = 16'd0;
              res0.role           = ROLE_MARKER;
              res0.section_marker = data_byte;
              res0.payload_length = 16'd0;
              phase_next = (data_byte == MARKER_SOI || data_byte == MARKER_EOI) ?
                           PH_SEEK : PH_LEN_HI;
            end
          end
        end
        default: begin
          n_results = 2'd1;
        end
      endcase
    end

    // A file that ends inside a segment, or inside a run of fill, is cut short.
    if (last_byte && n_results != 2'd0 && sticky_error_next == ERR_NONE &&
        !padding_mode_next) begin
      truncated = (phase_next == PH_LEN_HI) || (phase_next == PH_LEN_LO) ||
                  (phase_next == PH_PAYLOAD) ||
                  (phase_next == PH_SEEK && fill_count_next != 8'd0);
    end
    if (truncated) begin
      sticky_error_next = ERR_TRUNCATED;
      if (n_results == 2'd2) begin
        res1.role       = ROLE_DISCARDED;
        res1.error_code = ERR_TRUNCATED;
      end else begin
        res0.role       = ROLE_DISCARDED;
        res0.error_code = ERR_TRUNCATED;
      end
    end

    // Mark the last result of this byte.
    if (n_results == 2'd2) begin
      res1.run_end  = 1'b1;
      res1.file_end = last_byte;
    end else begin
      res0.run_end  = 1'b1;
      res0.file_end = last_byte;
    end

    // The final byte of a file returns the parser to its reset state.
    if (last_byte) begin
      phase_next           = PH_SEEK;
      fill_count_next      = 8'd0;
      current_marker_next  = 8'd0;
      length_high_next     = 8'd0;
      bytes_remaining_next = 16'd0;
      held_ff_next         = 1'b0;
      sticky_error_next    = ERR_NONE;
      padding_mode_next    = 1'b0;
      shown_len_next       = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_low      <= MARKER_LOW_RESET;
      marker_high     <= MARKER_HIGH_RESET;
      fill_limit      <= FILL_LIMIT_RESET;
      phase           <= PH_SEEK;
      fill_count      <= 8'd0;
      current_marker  <= 8'd0;
      length_high     <= 8'd0;
      bytes_remaining <= 16'd0;
      held_ff         <= 1'b0;
      sticky_error    <= ERR_NONE;
      padding_mode    <= 1'b0;
      shown_len       <= 16'd0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MARKER_LOW:  marker_low  <= cfg_data;
          REG_MARKER_HIGH: marker_high <= cfg_data;
          REG_FILL_LIMIT:  fill_limit  <= cfg_data;
          default: ;
        endcase
      end

      if (item_accept) begin
        phase           <= phase_next;
        fill_count      <= fill_count_next;
        current_marker  <= current_marker_next;
        length_high     <= length_high_next;
        bytes_remaining <= bytes_remaining_next;
        held_ff         <= held_ff_next;
        sticky_error    <= sticky_error_next;
        padding_mode    <= padding_mode_next;
        shown_len       <= shown_len_next;
        if (n_results != 2'd0) begin
          queue[wr_ptr] <= res0;
        end
        if (n_results == 2'd2) begin
          queue[wr_ptr + QPTR_W'(1)] <= res1;
        end
        wr_ptr <= wr_ptr + QPTR_W'(n_results);
      end

      if (result_accept) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end

      count <= count + (item_accept ? QCNT_W'(n_results) : QCNT_W'(0))
                     - (result_accept ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

endmodule

`default_nettype wire

// File: tb/jpeg_marker_segment_splitter_tb.sv
// Self-checking testbench for the JPEG marker segment splitter: a queued byte
// driver, a result monitor and a cycle-free predictor of the byte labelling.
// Depends on jmss_pkg and jpeg_marker_segment_splitter.
`timescale 1ns / 1ps

module jpeg_marker_segment_splitter_tb;
  import jmss_pkg::*;

  // Parser state of the predictor. These mirror the phases of the splitter
  // but are the testbench's own encoding.
  typedef enum logic [2:0] {
    SEEK_MARKER,
    READ_LEN_HI,
    READ_LEN_LO,
    IN_PAYLOAD,
    IN_SCAN
  } parse_state_t;

  // One byte of the input stream waiting to be driven.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  data_byte  = 8'h00;
  logic        last_byte  = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  role;
  logic [7:0]  section_marker;
  logic [15:0] payload_length;
  logic [2:0]  error_code;
  logic        file_end;
  logic        run_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MARKER_LOW;
  logic [7:0]  cfg_data  = 8'h00;

  always #5 clk = ~clk;

  jpeg_marker_segment_splitter dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .role           (role),
    .section_marker (section_marker),
    .payload_length (payload_length),
    .error_code     (error_code),
    .file_end       (file_end),
    .run_end        (run_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Bytes still to be driven, and the labels the splitter owes us.
  stream_byte_t pending [$];
  result_t      labels_due [$];
  logic [7:0]   file_buf [$];

  int items_accepted  = 0;
  int items_presented = 0;
  int bytes_queued    = 0;
  int files_queued    = 0;
  int settings_used   = 1;
  int labels_checked  = 0;
  int fault_count     = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;

  // Register mirrors, updated when a configuration transaction completes.
  logic [7:0] reg_low, reg_high, reg_fill_limit;

  // Predictor copy of the parser state.
  parse_state_t ps_phase;
  logic [7:0]   ps_fill;
  logic [7:0]   ps_marker;
  logic [7:0]   ps_len_hi;
  logic [15:0]  ps_remaining;
  logic         ps_held_ff;
  logic [2:0]   ps_error;
  logic         ps_padding;
  logic [15:0]  ps_shown_len;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // The parser returns here after reset and after the final byte of every
  // file; the registers are left alone.
  task automatic clear_parser();
    ps_phase     = SEEK_MARKER;
    ps_fill      = 8'd0;
    ps_marker    = 8'd0;
    ps_len_hi    = 8'd0;
    ps_remaining = 16'd0;
    ps_held_ff   = 1'b0;
    ps_error     = ERR_NONE;
    ps_padding   = 1'b0;
    ps_shown_len = 16'd0;
  endtask

  // A label picks up the shown length and the sticky error as they stand
  // at the moment it is made.
  function automatic result_t make_label(input logic [7:0] b, input logic [2:0] r,
                                         input logic [7:0] sec);
    result_t lab;
    lab.out_byte       = b;
    lab.role           = r;
    lab.section_marker = sec;
    lab.payload_length = ps_shown_len;
    lab.error_code     = ps_error;
    lab.file_end       = 1'b0;
    lab.run_end        = 1'b0;
    return lab;
  endfunction

  // After a payload the scan follows only for SOS; otherwise seek again.
  task automatic end_of_payload();
    ps_phase = (ps_marker == MARKER_SOS) ? IN_SCAN : SEEK_MARKER;
  endtask

  // Works out the zero, one or two labels that one accepted byte causes and
  // queues them in order.
  task automatic label_byte(input logic [7:0] b, input logic last);
    result_t     lab [2];
    int          n;
    logic [15:0] total;
    n = 0;
    if (ps_error != ERR_NONE) begin
      lab[n] = make_label(b, ROLE_DISCARDED, ps_marker);
      n++;
    end else if (ps_padding) begin
      lab[n] = make_label(b, ROLE_PADDING, ps_marker);
      n++;
    end else begin
      case (ps_phase)
        READ_LEN_HI: begin
          ps_len_hi = b;
          lab[n] = make_label(b, ROLE_LEN_HI, ps_marker);
          n++;
          ps_phase = READ_LEN_LO;
        end
        READ_LEN_LO: begin
          total = {ps_len_hi, b};
          if (total < 16'd2) begin
            ps_error = ERR_SHORT_LEN;
            lab[n] = make_label(b, ROLE_DISCARDED, ps_marker);
            n++;
          end else begin
            ps_shown_len = total - 16'd2;
            ps_remaining = ps_shown_len;
            lab[n] = make_label(b, ROLE_LEN_LO, ps_marker);
            n++;
            if (ps_remaining == 16'd0) end_of_payload();
            else ps_phase = IN_PAYLOAD;
          end
        end
        IN_PAYLOAD: begin
          lab[n] = make_label(b, ROLE_PAYLOAD, ps_marker);
          n++;
          ps_remaining = ps_remaining - 16'd1;
          if (ps_remaining == 16'd0) end_of_payload();
        end
        IN_SCAN: begin
          if (ps_held_ff) begin
            if (b == MARKER_EOI) begin
              // The held 0xFF turns out to be the prefix of EOI.
              ps_held_ff   = 1'b0;
              ps_marker    = MARKER_EOI;
              ps_shown_len = 16'd0;
              lab[n] = make_label(PREFIX_BYTE, ROLE_FILL, MARKER_EOI);
              n++;
              lab[n] = make_label(b, ROLE_MARKER, MARKER_EOI);
              n++;
              ps_padding = 1'b1;
            end else if (b == PREFIX_BYTE && !last) begin
              // Release the old 0xFF and hold the new one in its place.
              lab[n] = make_label(PREFIX_BYTE, ROLE_ENTROPY, ps_marker);
              n++;
            end else begin
              ps_held_ff = 1'b0;
              lab[n] = make_label(PREFIX_BYTE, ROLE_ENTROPY, ps_marker);
              n++;
              lab[n] = make_label(b, ROLE_ENTROPY, ps_marker);
              n++;
            end
          end else if (b == PREFIX_BYTE && !last) begin
            ps_held_ff = 1'b1;
          end else begin
            lab[n] = make_label(b, ROLE_ENTROPY, ps_marker);
            n++;
          end
        end
        default: begin
          if (b == PREFIX_BYTE) begin
            if (int'(ps_fill) + 1 >= int'(reg_fill_limit)) begin
              ps_error = ERR_NO_MARKER;
              lab[n] = make_label(b, ROLE_DISCARDED, ps_marker);
              n++;
            end else begin
              ps_fill = ps_fill + 8'd1;
              lab[n] = make_label(b, ROLE_FILL, 8'h00);
              n++;
            end
          end else if (ps_fill == 8'd0) begin
            ps_error = ERR_NO_MARKER;
            lab[n] = make_label(b, ROLE_DISCARDED, ps_marker);
            n++;
          end else begin
            ps_fill = 8'd0;
            if (b < reg_low || b > reg_high) begin
              ps_error = ERR_BAD_MARKER;
              lab[n] = make_label(b, ROLE_DISCARDED, ps_marker);
              n++;
            end else begin
              ps_marker    = b;
              ps_shown_len = 16'd0;
              lab[n] = make_label(b, ROLE_MARKER, b);
              n++;
              ps_phase = (b == MARKER_SOI || b == MARKER_EOI) ? SEEK_MARKER : READ_LEN_HI;
            end
          end
        end
      endcase
    end

    // A file that stops inside a length, a payload or a run of fill is
    // truncated: its final label is turned into a discard.
    if (last && n > 0 && ps_error == ERR_NONE && !ps_padding) begin
      if (ps_phase == READ_LEN_HI || ps_phase == READ_LEN_LO || ps_phase == IN_PAYLOAD ||
          (ps_phase == SEEK_MARKER && ps_fill != 8'd0)) begin
        ps_error = ERR_TRUNCATED;
        lab[n-1].role       = ROLE_DISCARDED;
        lab[n-1].error_code = ERR_TRUNCATED;
      end
    end
    if (n > 0) begin
      lab[n-1].run_end  = 1'b1;
      lab[n-1].file_end = last;
    end
    for (int i = 0; i < n; i++) labels_due.insert(labels_due.size(), lab[i]);
    if (last) clear_parser();
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued bytes at the falling edge and holds each one
  // until the transaction completes.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive_bytes
    stream_byte_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || items_accepted == items_presented) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending.pop_front();
        data_byte  <= nxt.data;
        last_byte  <= nxt.last;
        item_valid <= 1'b1;
        items_presented++;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: at the rising edge it mirrors register writes, feeds accepted
  // bytes to the predictor and checks each accepted result against the
  // oldest label still due. Prediction comes first so that a result in the
  // same cycle as its byte would still find its label.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    result_t got, want;
    if (rst) begin
      reg_low        = MARKER_LOW_RESET;
      reg_high       = MARKER_HIGH_RESET;
      reg_fill_limit = FILL_LIMIT_RESET;
      clear_parser();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MARKER_LOW:  reg_low        = cfg_data;
          REG_MARKER_HIGH: reg_high       = cfg_data;
          REG_FILL_LIMIT:  reg_fill_limit = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        label_byte(data_byte, last_byte);
        items_accepted++;
      end
      if (result_valid && !result_stall) begin
        got.out_byte       = out_byte;
        got.role           = role;
        got.section_marker = section_marker;
        got.payload_length = payload_length;
        got.error_code     = error_code;
        got.file_end       = file_end;
        got.run_end        = run_end;
        if (labels_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with no label due: byte %h role %0d", $realtime,
                     got.out_byte, got.role);
        end else begin
          want = labels_due.pop_front();
          labels_checked++;
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: label %0d expected %h role %0d sec %h len %0d err %0d end %b/%b",
                       $realtime, labels_checked, want.out_byte, want.role,
                       want.section_marker, want.payload_length, want.error_code,
                       want.file_end, want.run_end);
              $display("%0t: label %0d got      %h role %0d sec %h len %0d err %0d end %b/%b",
                       $realtime, labels_checked, got.out_byte, got.role,
                       got.section_marker, got.payload_length, got.error_code,
                       got.file_end, got.run_end);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  // Appends one byte to the file being assembled.
  task automatic file_add(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endtask

  // Moves the assembled file into the pending queue, flagging its last byte.
  task automatic emit_file();
    stream_byte_t sb;
    for (int i = 0; i < file_buf.size(); i++) begin
      sb.data = file_buf[i];
      sb.last = (i == file_buf.size() - 1);
      pending.insert(pending.size(), sb);
    end
    bytes_queued += file_buf.size();
    files_queued++;
    file_buf.delete();
  endtask

  // A prefix, now and then with extra fill; the extra fill may run past the
  // limit so that the too-much-fill error turns up too.
  task automatic add_marker(input logic [7:0] code);
    int lim;
    lim = (reg_fill_limit > 8'd12) ? 12 : int'(reg_fill_limit);
    file_add(PREFIX_BYTE);
    if ($urandom_range(3) == 0) repeat ($urandom_range(lim)) file_add(PREFIX_BYTE);
    file_add(code);
  endtask

  // Payloads are mostly tiny; a few run to some tens of bytes.
  task automatic add_segment(input logic [7:0] code);
    int plen;
    plen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
    add_marker(code);
    file_add(8'((plen + 2) >> 8));
    file_add(8'(plen + 2));
    repeat (plen) file_add(8'($urandom));
  endtask

  // A marker code from the configured range, steered away from the three
  // codes that change the framing.
  function automatic logic [7:0] segment_code();
    logic [7:0] c;
    c = 8'($urandom_range(reg_high, reg_low));
    if (c == MARKER_SOI || c == MARKER_EOI || c == MARKER_SOS) c = 8'hE1;
    return c;
  endfunction

  // Entropy data with a good share of 0xFF followed by stuffing, restart
  // codes, further 0xFF or anything at all.
  task automatic add_entropy();
    if ($urandom_range(3) == 0) begin
      file_add(PREFIX_BYTE);
      case ($urandom_range(3))
        0: file_add(8'h00);
        1: file_add(8'(8'hD0 + $urandom_range(7)));
        2: file_add(PREFIX_BYTE);
        default: file_add(8'($urandom));
      endcase
    end else begin
      file_add(8'($urandom));
    end
  endtask

  task automatic gen_file();
    int kind, cut, keep;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // Well-formed file, sometimes cut short or with one byte spoilt.
      add_marker(MARKER_SOI);
      repeat ($urandom_range(2)) begin
        if ($urandom_range(9) == 0) add_marker(MARKER_EOI);
        add_segment(segment_code());
      end
      add_segment(MARKER_SOS);
      repeat ($urandom_range(14)) add_entropy();
      if ($urandom_range(7) != 0) begin
        file_add(PREFIX_BYTE);
        file_add(MARKER_EOI);
        repeat ($urandom_range(3)) file_add(8'($urandom));
      end
      cut = $urandom_range(99);
      if (cut < 12) begin
        keep = $urandom_range(file_buf.size() - 1, 1);
        while (file_buf.size() > keep) void'(file_buf.pop_back());
      end else if (cut < 20) begin
        file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom);
      end
    end else if (kind < 82) begin
      // Noise, half of it starting with a prefix.
      repeat ($urandom_range(8, 1)) file_add(8'($urandom));
      if ($urandom_range(1) == 0) file_buf[0] = PREFIX_BYTE;
    end else if (kind < 90) begin
      // A length below two.
      add_marker(segment_code());
      file_add(8'h00);
      file_add(8'($urandom_range(1)));
      file_add(8'($urandom));
    end else begin
      // A scan that reaches the end of the file on an 0xFF.
      add_segment(MARKER_SOS);
      repeat ($urandom_range(4)) add_entropy();
      file_add(PREFIX_BYTE);
    end
    emit_file();
  endtask

  task automatic make_random_files(input int target);
    int goal;
    goal = bytes_queued + target;
    while (bytes_queued < goal) gen_file();
  endtask

  // Waits at falling edges until every byte is taken and every label has
  // come back, then lets the block settle before anything is changed.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending.size() != 0 || items_accepted != items_presented || labels_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Writes all three registers back to back; valid stays high between
  // transactions and only drops after the last one.
  task automatic set_config(input logic [7:0] low, input logic [7:0] high,
                            input logic [7:0] fill);
    logic [7:0] vals [3];
    logic [1:0] idx [3];
    vals = '{low, high, fill};
    idx  = '{REG_MARKER_LOW, REG_MARKER_HIGH, REG_FILL_LIMIT};
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence. Every phase is made of whole files so that the parser
  // is back at its start whenever the registers are rewritten.
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed files with the reset register values and no idling.
    // SOI, an empty SOS, held 0xFF runs, the scan-found EOI and padding.
    file_buf = '{PREFIX_BYTE, MARKER_SOI, PREFIX_BYTE, MARKER_SOS, 8'h00, 8'h02,
                 PREFIX_BYTE, PREFIX_BYTE, PREFIX_BYTE, MARKER_EOI, 8'h00};
    emit_file();
    // A file that does not start with a prefix.
    file_buf = '{8'h00};
    emit_file();
    // A marker code below the accepted range.
    file_buf = '{PREFIX_BYTE, 8'h01};
    emit_file();
    // A length of one, then a byte that is discarded under the sticky error.
    file_buf = '{PREFIX_BYTE, 8'hC4, 8'h00, 8'h01, 8'h55};
    emit_file();
    // The largest length, then truncation on the first payload byte.
    file_buf = '{PREFIX_BYTE, 8'hFE, 8'hFF, 8'hFF, 8'h00};
    emit_file();
    // A scan that ends on an 0xFF, which goes out at once.
    file_buf = '{PREFIX_BYTE, MARKER_SOS, 8'h00, 8'h02, PREFIX_BYTE};
    emit_file();
    // A file that ends inside a run of fill.
    file_buf = '{PREFIX_BYTE};
    emit_file();
    wait_until_drained();

    // Random files, reset registers, no idling.
    make_random_files(110);
    wait_until_drained();

    // Widest code range and fill limit, sender idling.
    set_config(8'h00, 8'hFF, 8'hFF);
    send_idle_pct = 47;
    make_random_files(110);
    wait_until_drained();

    // Smallest fill limit, receiver stalling. Two prefixes are already too
    // much fill here.
    set_config(MARKER_LOW_RESET, MARKER_HIGH_RESET, 8'd2);
    send_idle_pct = 0;
    stall_pct     = 47;
    file_buf = '{PREFIX_BYTE, PREFIX_BYTE};
    emit_file();
    make_random_files(110);
    wait_until_drained();

    // An empty code range, both sides idling.
    set_config(8'hFF, 8'h00, 8'd10);
    send_idle_pct = 25;
    stall_pct     = 25;
    make_random_files(110);
    wait_until_drained();

    // A narrow range around the framing codes, both sides idling.
    set_config(MARKER_SOI, MARKER_SOS, 8'd3);
    make_random_files(110);
    wait_until_drained();

    repeat (16) @(negedge clk);
    $display("Covered %0d bytes in %0d files under %0d register settings and four idling mixes;",
             bytes_queued, files_queued, settings_used);
    $display("%0d labels checked, %0d faults, %0d labels outstanding.",
             labels_checked, fault_count, labels_due.size());
    if (fault_count == 0 && labels_due.size() == 0) begin
      $display("jpeg_marker_segment_splitter_tb: done, clean");
    end else begin
      $display("jpeg_marker_segment_splitter_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin
    #5000000;
    $display("Timed out with %0d labels outstanding.", labels_due.size());
    $display("jpeg_marker_segment_splitter_tb: done, errors");
    $finish;
  end

endmodule
